@@ hw/rtl/tl_pkg.sv @@
// Package for the token lexer: character codes, token kinds, lexer state and result types.
`timescale 1ns / 1ps
`default_nettype none

package tl_pkg;

    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;
    localparam logic [CHAR_W-1:0] CH_COMMA     = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_SEMICOLON = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_HASH      = 8'h23;
    localparam logic [CHAR_W-1:0] CH_LPAREN    = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN    = 8'h29;
    localparam logic [CHAR_W-1:0] CH_PERIOD    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_QUOTE     = 8'h22;
    localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_DIGIT_0   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIGIT_9   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z   = 8'h7A;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_WORD   = 2'd1,
        MODE_STRING = 2'd2
    } lex_mode_t;

    typedef enum logic [1:0] {
        KIND_SEP    = 2'd0,
        KIND_WORD   = 2'd1,
        KIND_STRING = 2'd2,
        KIND_END    = 2'd3
    } token_kind_t;

    typedef struct packed {
        lex_mode_t         mode;
        logic              escape_pending;
        logic [CHAR_W-1:0] held_char;
        logic              held_valid;
    } lex_state_t;

    typedef struct packed {
        token_kind_t       kind;
        logic              has_char;
        logic [CHAR_W-1:0] token_char;
        logic              last;
    } result_t;

    function automatic logic is_word_char(input logic [CHAR_W-1:0] c);
        return (c == CH_UNDERSCORE) ||
               ((c >= CH_DIGIT_0) && (c <= CH_DIGIT_9)) ||
               ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
               ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
    endfunction

    function automatic logic is_separator(input logic [CHAR_W-1:0] c);
        return (c == CH_COMMA) || (c == CH_SEMICOLON) || (c == CH_NEWLINE) ||
               (c == CH_HASH) || (c == CH_LPAREN) || (c == CH_RPAREN) ||
               (c == CH_PERIOD);
    endfunction

    function automatic result_t make_result(input token_kind_t kind, input logic has,
                                            input logic [CHAR_W-1:0] ch, input logic last);
        result_t r;
        r.kind       = kind;
        r.has_char   = has;
        r.token_char = has ? ch : '0;
        r.last       = last;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tl_lex_core.sv @@
// Lexer state register and the per-character next-state and result logic.
`timescale 1ns / 1ps
`default_nettype none

module tl_lex_core (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    accept,
    input  wire logic [tl_pkg::CHAR_W-1:0] character,
    output logic [1:0]                   res_count,
    output tl_pkg::result_t              res0,
    output tl_pkg::result_t              res1
);
    import tl_pkg::*;

    lex_state_t state_reg, state_next;
    result_t    idle_res;
    logic       idle_res_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{mode: MODE_IDLE, escape_pending: 1'b0,
                           held_char: '0, held_valid: 1'b0};
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        res_count      = 2'd0;
        res0           = make_result(KIND_END, 1'b0, '0, 1'b1);
        res1           = make_result(KIND_END, 1'b0, '0, 1'b1);
        idle_res       = make_result(KIND_END, 1'b0, '0, 1'b1);
        idle_res_valid = 1'b0;

        unique case (state_reg.mode)
            MODE_STRING: begin
                if (character == CH_NUL) begin
                    // close the string, then end the text
                    res0 = make_result(KIND_STRING, state_reg.held_valid,
                                       state_reg.held_char, 1'b1);
                    res_count  = 2'd2;
                    state_next = '{mode: MODE_IDLE, escape_pending: 1'b0,
                                   held_char: '0, held_valid: 1'b0};
                end else if (state_reg.escape_pending || (character != CH_BACKSLASH &&
                                                          character != CH_QUOTE)) begin
                    res0 = make_result(KIND_STRING, 1'b1, state_reg.held_char, 1'b0);
                    res_count                 = state_reg.held_valid ? 2'd1 : 2'd0;
                    state_next.held_char      = character;
                    state_next.held_valid     = 1'b1;
                    state_next.escape_pending = 1'b0;
                end else if (character == CH_BACKSLASH) begin
                    state_next.escape_pending = 1'b1;
                end else begin
                    res0 = make_result(KIND_STRING, state_reg.held_valid,
                                       state_reg.held_char, 1'b1);
                    res_count  = 2'd1;
                    state_next = '{mode: MODE_IDLE, escape_pending: 1'b0,
                                   held_char: '0, held_valid: 1'b0};
                end
            end
            default: begin
                if (state_reg.mode == MODE_WORD) begin
                    res0      = make_result(KIND_WORD, 1'b1, state_reg.held_char,
                                            !is_word_char(character));
                    res_count = 2'd1;
                end
                if (state_reg.mode == MODE_WORD && is_word_char(character)) begin
                    state_next.held_char  = character;
                    state_next.held_valid = 1'b1;
                end else begin
                    // identifier closed (or none open): handle the character afresh
                    state_next.mode = MODE_IDLE;
                    if (state_reg.mode == MODE_WORD) begin
                        state_next.held_valid = 1'b0;
                        state_next.held_char  = '0;
                    end
                    if (character == CH_NUL) begin
                        state_next.escape_pending = 1'b0;
                        state_next.held_valid     = 1'b0;
                        idle_res_valid            = 1'b1;
                    end else if (is_separator(character)) begin
                        idle_res       = make_result(KIND_SEP, 1'b1, character, 1'b1);
                        idle_res_valid = 1'b1;
                    end else if (is_word_char(character)) begin
                        state_next.mode       = MODE_WORD;
                        state_next.held_char  = character;
                        state_next.held_valid = 1'b1;
                    end else if (character == CH_QUOTE) begin
                        state_next = '{mode: MODE_STRING, escape_pending: 1'b0,
                                       held_char: '0, held_valid: 1'b0};
                    end
                    if (idle_res_valid) begin
                        if (res_count == 2'd1) begin
                            res1 = idle_res;
                        end else begin
                            res0 = idle_res;
                        end
                        res_count = res_count + 2'd1;
                    end
                end
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/tl_out_queue.sv @@
// Result queue: takes up to two results a cycle, hands one a cycle to the output while it is ready.
`timescale 1ns / 1ps
`default_nettype none

module tl_out_queue #(
    parameter int unsigned DEPTH = tl_pkg::QUEUE_DEPTH
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic [1:0]      wr_count,
    input  tl_pkg::result_t      wr_data0,
    input  tl_pkg::result_t      wr_data1,
    output logic                 room_for_two,
    output logic                 rd_valid,
    input  wire logic            rd_ready,
    output tl_pkg::result_t      rd_data
);
    import tl_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    result_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next, wr_ptr_plus1, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               read_word;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign read_word    = rd_valid && rd_ready;
    assign rd_valid     = (count_reg != '0);
    assign rd_data      = entry_reg[rd_ptr_reg];
    assign room_for_two = (count_reg <= CNT_W'(DEPTH - 2));
    assign wr_ptr_plus1 = wrap_inc(wr_ptr_reg);

    always_comb begin
        rd_ptr_next = read_word ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        unique case (wr_count)
            2'd1:    wr_ptr_next = wr_ptr_plus1;
            2'd2:    wr_ptr_next = wrap_inc(wr_ptr_plus1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        count_next = count_reg + CNT_W'(wr_count) - CNT_W'(read_word);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= wr_data0;
        end
        if (wr_count == 2'd2) begin
            entry_reg[wr_ptr_plus1] <= wr_data1;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/token_lexer.sv @@
// Top level of the token lexer: character stream in, token character stream out.
//
// Input channel s_*: one text character per word in s_tdata[7:0]; a zero
// character ends the text. Output channel m_*: one token character per word
// in m_tdata, with the token kind and a has-character flag in m_tuser and
// m_tlast set on the final word of each token. Separators, empty strings and
// the end-of-text marker are single words with m_tlast high.
// Identifier and string characters are held back by one character so that the
// final one can carry m_tlast; a character therefore appears on m_* only once
// the character after it has been accepted.
// Output: results of an accepted character are registered in the queue and
// reach m_* behind any words already queued.
// Throughput: one character per cycle while the result queue has room for two
// words; a character that closes a token and is a separator or end of text
// yields two words, and the single output word per cycle then sets the pace.
// Stall: while m_tready is low, hold the current word; s_tready drops once the
// queue of QUEUE_DEPTH words could no longer take two more.
// Reset (aresetn low, synchronous): empty the queue, return the lexer to idle
// with no held character and no pending escape.
`timescale 1ns / 1ps
`default_nettype none

module token_lexer #(
    parameter int unsigned QUEUE_DEPTH = tl_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] character
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] token_char
    output logic [2:0]       m_tuser,   // [1:0] token_kind, [2] has_char
    output logic             m_tlast
);
    import tl_pkg::*;

    logic       accept;
    logic [1:0] res_count;
    logic [1:0] push_count;
    result_t    res0, res1, head;
    logic       room_for_two;

    // take a word only while the queue can absorb the worst case of two results
    assign s_tready   = room_for_two;
    assign accept     = s_tvalid && s_tready;
    assign push_count = accept ? res_count : 2'd0;

    tl_lex_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .character (s_tdata[CHAR_W-1:0]),
        .res_count (res_count),
        .res0      (res0),
        .res1      (res1)
    );

    tl_out_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .wr_count     (push_count),
        .wr_data0     (res0),
        .wr_data1     (res1),
        .room_for_two (room_for_two),
        .rd_valid     (m_tvalid),
        .rd_ready     (m_tready),
        .rd_data      (head)
    );

    // present the head result: character on tdata, kind and flag on tuser
    assign m_tdata = head.token_char;
    assign m_tuser = {head.has_char, head.kind};
    assign m_tlast = head.last;

endmodule

`default_nettype wire

@@ hw/rtl/token_lexer_checker.sv @@
// Port-level checks for the token lexer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module token_lexer_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        m_tlast
);
    import tl_pkg::*;

    // a stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
        $stable(m_tlast))
        else $error("output word changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output valid or input not ready right after reset");

    a_end_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1:0] == KIND_END) |-> m_tlast && !m_tuser[2] &&
        (m_tdata == 8'd0))
        else $error("malformed end-of-text word");

    a_sep_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1:0] == KIND_SEP) |-> m_tlast && m_tuser[2])
        else $error("malformed separator word");

    a_no_char_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[2] |-> m_tlast && (m_tuser[1:0] != KIND_WORD) &&
        (m_tdata == 8'd0))
        else $error("word without character not a closing word");

endmodule

bind token_lexer token_lexer_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
